[rtl/rigid_transform_stack_top_assert.svh]
// Assertion macros for the rigid transform stack.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef RIGID_TRANSFORM_STACK_TOP_ASSERT_SVH
`define RIGID_TRANSFORM_STACK_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RTS_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define RTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[rtl/rts_pkg.sv]
// Shared types, constants and helpers for the rigid transform stack.
// No dependencies.
`timescale 1ns / 1ps
package rts_pkg;
   localparam int unsigned StackDepthDefault = 32;
   localparam int unsigned LevelWidth = 6;
   localparam logic signed [15:0] Q14One = 16'sd16384;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_QUERY = 2'd2,
      OP_SPARE = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [47:0]        right_column;
      logic [47:0]        up_column;
      logic [47:0]        forward_column;
   } req_type;

   typedef struct packed {
      logic [47:0]        top_row0;
      logic [47:0]        top_row1;
      logic [47:0]        top_row2;
      logic signed [31:0] top_x;
      logic signed [31:0] top_y;
      logic signed [31:0] top_z;
      logic [5:0]         level;
      logic               refused;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load;       // capture request
      logic       clear_acc;  // zero the accumulator
      logic       mac;        // accumulate one product
      logic [1:0] row;        // parent row r
      logic [1:0] k;          // inner index
      logic [1:0] col;        // 0..2 rotation column, 3 translation
      logic       store_term; // latch finished term into row buffer
      logic       write_row;  // write row buffer to stores
      logic       use_ident;  // parent is the empty-stack identity
      logic       load_row;   // capture parent row from the stores
   } cmd_type;

   function automatic logic signed [15:0] term16(input logic [47:0] packed_v,
                                                 input logic [1:0] i);
      case (i)
         2'd0:    term16 = packed_v[15:0];
         2'd1:    term16 = packed_v[31:16];
         default: term16 = packed_v[47:32];
      endcase
   endfunction
endpackage

[rtl/rts_if.sv]
// Valid/ready channel interface carrying one payload type.
// No dependencies.
`timescale 1ns / 1ps
interface rts_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/rts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rts_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/rts_datapath.sv]
// Datapath: captured request, stores, one shared multiply-accumulate unit.
// Depends on rts_pkg and rts_ram.
`timescale 1ns / 1ps
module rts_datapath #(
   parameter int unsigned StackDepth = rts_pkg::StackDepthDefault,
   localparam int unsigned AddrWidth = $clog2(3 * StackDepth)
) (
   input  logic                 clock,
   input  rts_pkg::cmd_type     cmd,
   input  rts_pkg::req_type     req_data,
   input  logic [AddrWidth-1:0] rd_addr,
   input  logic [AddrWidth-1:0] wr_addr,
   output logic [47:0]          rot_rd,
   output logic [31:0]          tr_rd
);
   rts_pkg::req_type req_ff;
   logic signed [15:0] prow_ff [3];
   logic signed [31:0] ptr_ff;
   logic signed [50:0] acc_ff, acc_in;
   logic signed [47:0] prod_ff;
   logic               prod_vld_ff;
   logic [47:0]        row_ff;
   logic [31:0]        trw_ff;
   logic [47:0]        rot_q;
   logic [31:0]        tr_q;
   logic signed [15:0] pa;
   logic signed [31:0] pb;
   logic signed [36:0] sh;
   logic signed [37:0] tsum;
   logic signed [15:0] rterm;
   logic signed [31:0] tterm;

   // parent row held in registers, loaded from RAM or identity
   always_comb begin
      pa = prow_ff[cmd.k];
      if (cmd.col == 2'd3) begin
         case (cmd.k)
            2'd0:    pb = req_ff.pos_x;
            2'd1:    pb = req_ff.pos_y;
            default: pb = req_ff.pos_z;
         endcase
      end else begin
         pb = 32'(signed'(rts_pkg::term16(
            cmd.col == 2'd0 ? req_ff.right_column :
            cmd.col == 2'd1 ? req_ff.up_column : req_ff.forward_column, cmd.k)));
      end
      acc_in = acc_ff + (prod_vld_ff ? 51'(prod_ff) : 51'sd0);
      sh = 37'(acc_in >>> 14);
      if (sh > 37'sd32767) rterm = 16'sh7fff;
      else if (sh < -37'sd32768) rterm = 16'sh8000;
      else rterm = 16'(sh);
      tsum = 38'(sh) + 38'(ptr_ff);
      if (tsum > 38'sd2147483647) tterm = 32'sh7fffffff;
      else if (tsum < -38'sd2147483648) tterm = 32'sh80000000;
      else tterm = 32'(tsum);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      prod_ff     <= pa * pb;
      prod_vld_ff <= cmd.mac;
      if (cmd.clear_acc) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      if (cmd.store_term) begin
         if (cmd.col == 2'd3) trw_ff <= tterm;
         else row_ff[16*cmd.col +: 16] <= rterm;
      end
      if (cmd.use_ident) begin
         for (int i = 0; i < 3; i++) begin
            prow_ff[i] <= (2'(i) == cmd.row) ? rts_pkg::Q14One : 16'sd0;
         end
         ptr_ff <= '0;
      end else if (cmd.load_row) begin
         prow_ff[0] <= rot_q[15:0];
         prow_ff[1] <= rot_q[31:16];
         prow_ff[2] <= rot_q[47:32];
         ptr_ff     <= tr_q;
      end
   end

   rts_ram #(.Width(48), .Depth(3 * StackDepth)) u_rot_ram (
      .clock, .wr_en(cmd.write_row), .wr_addr, .wr_data(row_ff),
      .rd_addr, .rd_data(rot_q));
   rts_ram #(.Width(32), .Depth(3 * StackDepth)) u_tr_ram (
      .clock, .wr_en(cmd.write_row), .wr_addr, .wr_data(trw_ff),
      .rd_addr, .rd_data(tr_q));

   assign rot_rd = rot_q;
   assign tr_rd  = tr_q;
endmodule

[rtl/rts_ctrl.sv]
// Controller: sequences push composition, pops, queries and the response.
// Depends on rts_pkg and rigid_transform_stack_top_assert.svh; drives rts_datapath.
`timescale 1ns / 1ps
`include "rigid_transform_stack_top_assert.svh"
module rts_ctrl #(
   parameter int unsigned StackDepth = rts_pkg::StackDepthDefault,
   localparam int unsigned AddrWidth = $clog2(3 * StackDepth),
   localparam int unsigned CntWidth = $clog2(StackDepth + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [5:0]           rsp_level,
   output logic                 rsp_refused,
   output logic                 rsp_ident,
   output logic [1:0]           rsp_row,
   output logic                 rsp_row_we,
   output rts_pkg::cmd_type     cmd,
   output logic [AddrWidth-1:0] rd_addr,
   output logic [AddrWidth-1:0] wr_addr
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_LOADP, ST_MAC, ST_FIN, ST_RDTOP, ST_RDWAIT, ST_OUT
   } state_type;

   state_type           state_ff;
   logic [CntWidth-1:0] level_ff;
   logic [1:0]          row_ff, col_ff, k_ff, rdrow_ff;
   logic [2:0]          drain_ff;
   logic                refused_ff, rsp_valid_ff;

   function automatic logic [AddrWidth-1:0] addr_of(input logic [CntWidth-1:0] e,
                                                     input logic [1:0] r);
      addr_of = AddrWidth'(3 * int'(e) + int'(r));
   endfunction

   logic ident_now;
   assign ident_now = (level_ff == '0);

   always_comb begin
      cmd = '0;
      cmd.row = row_ff;
      cmd.col = col_ff;
      cmd.k   = k_ff;
      cmd.load = req_valid && req_ready;
      rd_addr = addr_of(ident_now ? '0 : level_ff - 1'b1, rdrow_ff);
      wr_addr = addr_of(level_ff, row_ff);
      case (state_ff)
         ST_LOADP: begin
            cmd.clear_acc = drain_ff == 3'd1;
            cmd.use_ident = (drain_ff == 3'd1) && ident_now;
            cmd.load_row  = (drain_ff == 3'd1) && !ident_now;
            cmd.col = 2'd0;
         end
         ST_MAC:  cmd.mac = 1'b1;
         ST_FIN: begin
            cmd.store_term = drain_ff == 3'd0;
            cmd.write_row  = drain_ff == 3'd1;
            cmd.clear_acc  = 1'b1;
         end
         default: ;
      endcase
   end

   // Push: per row, load parent row, then 4 columns x (3 MACs + drain), then write the row.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= '0;
         rsp_valid_ff <= 1'b0;
         refused_ff <= 1'b0;
         row_ff <= '0; col_ff <= '0; k_ff <= '0; rdrow_ff <= '0;
         drain_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  row_ff <= '0; rdrow_ff <= '0;
                  if (req_opcode == rts_pkg::OP_PUSH) begin
                     refused_ff <= (32'(level_ff) >= StackDepth);
                     if (32'(level_ff) >= StackDepth) begin
                        state_ff <= ST_RDTOP;
                     end else begin
                        drain_ff <= '0;
                        state_ff <= ST_LOADP;
                     end
                  end else begin
                     refused_ff <= (req_opcode == rts_pkg::OP_POP) && (level_ff == '0);
                     if (req_opcode == rts_pkg::OP_POP && level_ff != '0) begin
                        level_ff <= level_ff - 1'b1;
                     end
                     state_ff <= ST_RDTOP;
                  end
               end
            end
            ST_LOADP: begin
               if (drain_ff == 3'd1) begin
                  col_ff <= '0; k_ff <= '0; drain_ff <= '0;
                  state_ff <= ST_MAC;
               end else begin
                  drain_ff <= drain_ff + 3'd1;
               end
            end
            ST_MAC: begin
               if (k_ff == 2'd2) begin
                  k_ff <= '0;
                  drain_ff <= '0;
                  state_ff <= ST_FIN;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            ST_FIN: begin
               if (drain_ff == 3'd0 && col_ff != 2'd3) begin
                  col_ff <= col_ff + 2'd1;
                  state_ff <= ST_MAC;
               end else if (drain_ff == 3'd0) begin
                  drain_ff <= 3'd1;
               end else begin
                  if (row_ff == 2'd2) begin
                     level_ff <= level_ff + 1'b1;
                     rdrow_ff <= '0;
                     state_ff <= ST_RDTOP;
                  end else begin
                     row_ff <= row_ff + 2'd1;
                     rdrow_ff <= rdrow_ff + 2'd1;
                     drain_ff <= '0;
                     state_ff <= ST_LOADP;
                  end
               end
            end
            ST_RDTOP: begin
               state_ff <= ST_RDWAIT;
            end
            ST_RDWAIT: begin
               if (rdrow_ff == 2'd2) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  rdrow_ff <= rdrow_ff + 2'd1;
                  state_ff <= ST_RDTOP;
               end
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_level   = 6'(level_ff);
   assign rsp_refused = refused_ff;
   assign rsp_ident   = ident_now;
   assign rsp_row     = rdrow_ff;
   assign rsp_row_we  = (state_ff == ST_RDWAIT);

   `RTS_ASSERT_IMPL(a_level_bound, clock, reset, 32'(level_ff) <= StackDepth,
      "level beyond depth")
   `RTS_ASSERT_IMPL(a_no_accept_busy, clock, reset,
      (state_ff != ST_IDLE) |-> !req_ready, "ready while busy")
   `RTS_ASSERT_IMPL(a_rsp_only_out, clock, reset,
      rsp_valid |-> (state_ff == ST_OUT), "response outside output state")
   `RTS_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid,
      "response after reset")
endmodule

[rtl/rigid_transform_stack_top.sv]
// Rigid transform stack: a stack of 3x3 Q2.14 rotations with Q16.16
// translations. Request channel req_*, response channel rsp_*.
// Each request gives exactly one response: the top entry after the request,
// the level, and a refused flag (push on full, pop on empty).
// A push composes parent and local transform with one shared multiplier:
// per row, the parent row is fetched, then four columns of three
// multiply-accumulates plus a finish step, and a row write. The top entry
// is then read back row by row before rsp_valid rises; a pop or query
// reads the top back in the same way.
// The multiply-accumulate loop sets the push time.
// One request is in flight at a time; req_ready is high only when idle.
// The response is held until rsp_ready; no new request is taken meanwhile.
// Synchronous reset empties the stack; the stores themselves are not
// cleared, since an entry is always written before it is read.
// Depends on rts_pkg, rts_if, rts_ctrl, rts_datapath, rts_ram.
`timescale 1ns / 1ps
module rigid_transform_stack_top #(
   parameter int unsigned STACK_DEPTH = rts_pkg::StackDepthDefault
) (
   input logic clock,
   input logic reset,
   rts_if.sink   req,
   rts_if.source rsp
);
   localparam int unsigned AddrWidth = $clog2(3 * STACK_DEPTH);
   rts_pkg::cmd_type     cmd;
   logic [AddrWidth-1:0] rd_addr, wr_addr;
   logic [47:0]          rot_rd;
   logic [31:0]          tr_rd;
   logic [5:0]           level;
   logic                 refused, ident, row_we;
   logic [1:0]           row;
   logic [47:0]          orow_ff [3];
   logic [31:0]          otr_ff [3];
   logic [47:0]          ident_row;
   rts_pkg::rsp_type     out;

   rts_ctrl #(.StackDepth(STACK_DEPTH)) u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .req_opcode(req.payload.opcode),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_level(level), .rsp_refused(refused), .rsp_ident(ident),
      .rsp_row(row), .rsp_row_we(row_we),
      .cmd, .rd_addr, .wr_addr);

   rts_datapath #(.StackDepth(STACK_DEPTH)) u_dp (
      .clock, .cmd, .req_data(req.payload), .rd_addr, .wr_addr,
      .rot_rd, .tr_rd);

   always_comb begin
      ident_row = '0;
      ident_row[16*row +: 16] = rts_pkg::Q14One;
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         orow_ff[row] <= ident ? ident_row : rot_rd;
         otr_ff[row]  <= ident ? 32'd0 : tr_rd;
      end
   end

   always_comb begin
      out.top_row0 = orow_ff[0];
      out.top_row1 = orow_ff[1];
      out.top_row2 = orow_ff[2];
      out.top_x    = otr_ff[0];
      out.top_y    = otr_ff[1];
      out.top_z    = otr_ff[2];
      out.level    = level;
      out.refused  = refused;
   end
   assign rsp.payload = out;
endmodule

[bench/rigid_transform_stack_top_test.sv]
// Self-checking bench for the rigid transform stack: drives push/pop/query
// and spare-opcode transfers and compares each response with an in-bench stack model.
// Depends on rts_pkg, rts_if and rigid_transform_stack_top.
`timescale 1ns / 1ps
module rigid_transform_stack_top_test;
   localparam int unsigned Depth = rts_pkg::StackDepthDefault;

   logic clock;
   logic reset;
   rts_if #(.payload_type(rts_pkg::req_type)) req_ch (clock);
   rts_if #(.payload_type(rts_pkg::rsp_type)) rsp_ch (clock);

   rigid_transform_stack_top #(.STACK_DEPTH(Depth)) u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   rts_pkg::req_type pending_reqs[$];
   rts_pkg::rsp_type expected_tops[$];
   logic [47:0] rot_mem[3*Depth];
   logic [31:0] trn_mem[3*Depth];
   int unsigned stack_lvl;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         errors;
   int         refusals, responses;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor14(input longint s);
      return s >>> 14;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint rot_term(input logic [47:0] p, input int i);
      logic signed [15:0] t;
      t = p[16*i +: 16];
      return longint'(t);
   endfunction

   function automatic rts_pkg::rsp_type top_entry();
      rts_pkg::rsp_type o;
      o = '0;
      if (stack_lvl == 0) begin
         o.top_row0 = {16'd0, 16'd0, 16'd16384};
         o.top_row1 = {16'd0, 16'd16384, 16'd0};
         o.top_row2 = {16'd16384, 16'd0, 16'd0};
      end else begin
         o.top_row0 = rot_mem[(stack_lvl-1)*3];
         o.top_row1 = rot_mem[(stack_lvl-1)*3+1];
         o.top_row2 = rot_mem[(stack_lvl-1)*3+2];
         o.top_x = trn_mem[(stack_lvl-1)*3];
         o.top_y = trn_mem[(stack_lvl-1)*3+1];
         o.top_z = trn_mem[(stack_lvl-1)*3+2];
      end
      o.level = stack_lvl[5:0];
      return o;
   endfunction

   function automatic rts_pkg::rsp_type apply_request(input rts_pkg::req_type r);
      rts_pkg::rsp_type par, o;
      longint      prot[3][3], ptr[3], loc[3][3], pos[3];
      longint      s, acc;
      logic [47:0] cols[3];
      logic [47:0] prow[3];
      logic [47:0] row;
      bit          refused;
      refused = 1'b0;
      if (r.opcode == rts_pkg::OP_PUSH) begin
         if (stack_lvl >= Depth) refused = 1'b1;
         else begin
            par = top_entry();
            prow[0] = par.top_row0; prow[1] = par.top_row1; prow[2] = par.top_row2;
            ptr[0] = par.top_x; ptr[1] = par.top_y; ptr[2] = par.top_z;
            cols[0] = r.right_column; cols[1] = r.up_column; cols[2] = r.forward_column;
            pos[0] = r.pos_x; pos[1] = r.pos_y; pos[2] = r.pos_z;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++) begin
                  prot[i][j] = rot_term(prow[i], j);
                  loc[j][i] = rot_term(cols[i], j);
               end
            for (int i = 0; i < 3; i++) begin
               row = '0;
               for (int c = 0; c < 3; c++) begin
                  s = 0;
                  for (int k = 0; k < 3; k++) s += prot[i][k] * loc[k][c];
                  s = clamp(floor14(s), -32768, 32767);
                  row[16*c +: 16] = s[15:0];
               end
               acc = 0;
               for (int k = 0; k < 3; k++) acc += prot[i][k] * pos[k];
               acc = clamp(floor14(acc) + ptr[i], -64'sd2147483648, 64'sd2147483647);
               rot_mem[stack_lvl*3+i] = row;
               trn_mem[stack_lvl*3+i] = acc[31:0];
            end
            stack_lvl++;
         end
      end else if (r.opcode == rts_pkg::OP_POP) begin
         if (stack_lvl == 0) refused = 1'b1;
         else stack_lvl--;
      end
      o = top_entry();
      o.refused = refused;
      return o;
   endfunction

   function automatic logic [15:0] rand_q14();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'd16384;
         3: return 16'hC000;
         4: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic rts_pkg::req_type rand_push();
      rts_pkg::req_type r;
      r.opcode = rts_pkg::OP_PUSH;
      r.pos_x = rand_pos(); r.pos_y = rand_pos(); r.pos_z = rand_pos();
      r.right_column = {rand_q14(), rand_q14(), rand_q14()};
      r.up_column = {rand_q14(), rand_q14(), rand_q14()};
      r.forward_column = {rand_q14(), rand_q14(), rand_q14()};
      return r;
   endfunction

   function automatic rts_pkg::req_type make_op(input rts_pkg::opcode_type op);
      rts_pkg::req_type r;
      r = rand_push();
      r.opcode = op;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) expected_tops.push_back(apply_request(req_ch.payload));
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.payload <= pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rts_pkg::rsp_type exp_rsp;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            responses++;
            if (expected_tops.size() == 0) begin
               $error("unexpected response transfer");
               errors++;
            end else begin
               exp_rsp = expected_tops.pop_front();
               if (rsp_ch.payload.top_row0 !== exp_rsp.top_row0) begin
                  $error("top_row0 exp %h got %h", exp_rsp.top_row0, rsp_ch.payload.top_row0);
                  errors++;
               end
               if (rsp_ch.payload.top_row1 !== exp_rsp.top_row1) begin
                  $error("top_row1 exp %h got %h", exp_rsp.top_row1, rsp_ch.payload.top_row1);
                  errors++;
               end
               if (rsp_ch.payload.top_row2 !== exp_rsp.top_row2) begin
                  $error("top_row2 exp %h got %h", exp_rsp.top_row2, rsp_ch.payload.top_row2);
                  errors++;
               end
               if (rsp_ch.payload.top_x !== exp_rsp.top_x) begin
                  $error("top_x exp %h got %h", exp_rsp.top_x, rsp_ch.payload.top_x);
                  errors++;
               end
               if (rsp_ch.payload.top_y !== exp_rsp.top_y) begin
                  $error("top_y exp %h got %h", exp_rsp.top_y, rsp_ch.payload.top_y);
                  errors++;
               end
               if (rsp_ch.payload.top_z !== exp_rsp.top_z) begin
                  $error("top_z exp %h got %h", exp_rsp.top_z, rsp_ch.payload.top_z);
                  errors++;
               end
               if (rsp_ch.payload.level !== exp_rsp.level) begin
                  $error("level exp %0d got %0d", exp_rsp.level, rsp_ch.payload.level);
                  errors++;
               end
               if (rsp_ch.payload.refused !== exp_rsp.refused) begin
                  $error("refused exp %0b got %0b", exp_rsp.refused, rsp_ch.payload.refused);
                  errors++;
               end
               if (exp_rsp.refused) refusals++;
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      rts_pkg::req_type r;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 48;
      errors = 0; refusals = 0; responses = 0;
      stack_lvl = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-stack pop/query, spare opcode, extremes, identity push
      pending_reqs.push_back(make_op(rts_pkg::OP_POP));
      pending_reqs.push_back(make_op(rts_pkg::OP_QUERY));
      pending_reqs.push_back(make_op(rts_pkg::OP_SPARE));
      r = make_op(rts_pkg::OP_PUSH);
      r.right_column = {16'd0, 16'd0, 16'd16384};
      r.up_column = {16'd0, 16'd16384, 16'd0};
      r.forward_column = {16'd16384, 16'd0, 16'd0};
      r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h8000_0000; r.pos_z = 32'h0001_0000;
      pending_reqs.push_back(r);
      r.right_column = {3{16'h8000}}; r.up_column = {3{16'h8000}};
      r.forward_column = {3{16'h8000}};
      r.pos_x = 32'h8000_0000; r.pos_y = 32'h8000_0000; r.pos_z = 32'h8000_0000;
      pending_reqs.push_back(r);
      r.right_column = {3{16'h7FFF}}; r.up_column = {3{16'h7FFF}};
      r.forward_column = {3{16'h7FFF}};
      r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h7FFF_FFFF; r.pos_z = 32'hFFFF_FFFF;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_op(rts_pkg::OP_QUERY));
      for (int i = 0; i < 3; i++) pending_reqs.push_back(make_op(rts_pkg::OP_POP));
      pending_reqs.push_back(make_op(rts_pkg::OP_POP));
      // fill to the top, then one refused push, then drain and one refused pop
      for (int i = 0; i < Depth + 1; i++) pending_reqs.push_back(rand_push());
      for (int i = 0; i < Depth + 1; i++) pending_reqs.push_back(make_op(rts_pkg::OP_POP));

      // random: walk the level up and down, biased to visit both ends
      for (int i = 0; i < 1850; i++) begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < ((i / 200) % 2 ? 35 : 60)) begin
            pending_reqs.push_back(rand_push());
         end else if (pick < 92) begin
            pending_reqs.push_back(make_op(rts_pkg::OP_POP));
         end else begin
            pending_reqs.push_back(make_op($urandom_range(0, 1) ? rts_pkg::OP_QUERY :
                                           rts_pkg::OP_SPARE));
         end
         if (i == 620) begin
            wait (pending_reqs.size() == 0);
            send_idle_pct = 48;
            recv_idle_pct = 20;
         end
         if (i == 1240) begin
            wait (pending_reqs.size() == 0);
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_ch.valid);
      wait (expected_tops.size() == 0);
      repeat (80) @(posedge clock);
      $display("Covered %0d responses, including %0d refused pushes/pops, to depth %0d.",
               responses, refusals, Depth);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl
rtl/rts_pkg.sv
rtl/rts_if.sv
rtl/rts_ram.sv
rtl/rts_datapath.sv
rtl/rts_ctrl.sv
rtl/rigid_transform_stack_top.sv
bench/rigid_transform_stack_top_test.sv
